FILE: sv/mfd_pkg.sv
`default_nettype none

package mfd_pkg;

  localparam logic [7:0] SyncByte     = 8'hFF;
  localparam int         PayloadBytes = 8;
  localparam logic [7:0] CheckAdd     = 8'd1;
  localparam int         IndexW       = 4;

  // frame search phase, one-hot
  typedef enum logic [2:0] {
    PH_HUNT    = 3'b001,
    PH_ONE_FF  = 3'b010,
    PH_COLLECT = 3'b100
  } phase_e;

  // finished frame as seen by the result stage
  typedef struct packed {
    logic        done;
    logic        good;
    logic [31:0] left;
    logic [31:0] right;
  } frame_t;

endpackage

`default_nettype wire

FILE: sv/mfd_deframer.sv
`default_nettype none

module mfd_deframer
  import mfd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] byte_i,
  output frame_t          frame_o
);

  phase_e               phase_q, phase_d;
  logic [IndexW-1:0]    index_q, index_d;
  logic [63:0]          shift_q, shift_d;
  logic [7:0]           xor_q, xor_d;
  logic                 last_byte;

  assign last_byte = (phase_q == PH_COLLECT) &&
                     (index_q == IndexW'(PayloadBytes));

  // frame report for the current byte
  always_comb begin
    frame_o.done  = last_byte;
    frame_o.good  = ((xor_q + CheckAdd) == byte_i);
    frame_o.right = shift_q[63:32];
    frame_o.left  = shift_q[31:0];
  end

  // sync hunt and payload collection
  always_comb begin
    phase_d = phase_q;
    index_d = index_q;
    shift_d = shift_q;
    xor_d   = xor_q;
    case (phase_q)
      PH_HUNT: begin
        if (byte_i == SyncByte) phase_d = PH_ONE_FF;
      end
      PH_ONE_FF: begin
        if (byte_i == SyncByte) begin
          phase_d = PH_COLLECT;
          index_d = '0;
          shift_d = '0;
          xor_d   = '0;
        end else begin
          phase_d = PH_HUNT;
        end
      end
      PH_COLLECT: begin
        if (last_byte) begin
          phase_d = PH_HUNT;
          index_d = '0;
        end else begin
          shift_d = {shift_q[55:0], byte_i};
          xor_d   = xor_q ^ byte_i;
          index_d = index_q + IndexW'(1);
        end
      end
      default: begin
        phase_d = PH_HUNT;
        index_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      index_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      index_q <= index_d;
    end
  end

  // frame data, cleared at each frame start
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      shift_q <= shift_d;
      xor_q   <= xor_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/mfd_result.sv
`default_nettype none

module mfd_result
  import mfd_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          load_i,
  input  wire frame_t        frame_i,
  input  wire logic          out_stall_i,
  output logic               out_valid_o,
  output logic               frame_status_o,
  output logic signed [31:0] left_count_o,
  output logic signed [31:0] right_count_o,
  output logic signed [31:0] left_change_o,
  output logic signed [31:0] right_change_o
);

  logic        valid_q;
  logic        status_q;
  logic [31:0] left_q, right_q, dleft_q, dright_q;
  logic [31:0] prev_left_q, prev_right_q;
  logic        good_load;

  assign good_load = load_i && frame_i.good;

  // previous good counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_left_q  <= '0;
      prev_right_q <= '0;
    end else if (good_load) begin
      prev_left_q  <= frame_i.left;
      prev_right_q <= frame_i.right;
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  // result payload, zero on mismatch
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      status_q <= !frame_i.good;
      if (frame_i.good) begin
        left_q   <= frame_i.left;
        right_q  <= frame_i.right;
        dleft_q  <= frame_i.left - prev_left_q;
        dright_q <= frame_i.right - prev_right_q;
      end else begin
        left_q   <= '0;
        right_q  <= '0;
        dleft_q  <= '0;
        dright_q <= '0;
      end
    end
  end

  assign out_valid_o    = valid_q;
  assign frame_status_o = status_q;
  assign left_count_o   = left_q;
  assign right_count_o  = right_q;
  assign left_change_o  = dleft_q;
  assign right_change_o = dright_q;

endmodule

`default_nettype wire

FILE: sv/motor_feedback_deframer.sv
// byte path: input register, then deframer; frame results land in the result register
// throughput: one byte per cycle; a frame-ending byte waits while the last result is held
// the input register and the result register part the two channels
// reset: asynchronous, active low; hunting for sync, previous counts zero
`default_nettype none

module motor_feedback_deframer
  import mfd_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic [7:0]    rx_byte_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic               frame_status_o,
  output logic signed [31:0] left_count_o,
  output logic signed [31:0] right_count_o,
  output logic signed [31:0] left_change_o,
  output logic signed [31:0] right_change_o
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       step;
  logic       accept;
  frame_t     frame;

  // a frame-ending byte needs an empty result register
  assign step       = in_valid_q && !(frame.done && out_valid_o);
  assign in_stall_o = in_valid_q && !step;
  assign accept     = in_valid_i && !in_stall_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q <= rx_byte_i;
    end
  end

  mfd_deframer u_deframer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .byte_i  (in_byte_q),
    .frame_o (frame)
  );

  mfd_result u_result (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (step && frame.done),
    .frame_i        (frame),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .frame_status_o (frame_status_o),
    .left_count_o   (left_count_o),
    .right_count_o  (right_count_o),
    .left_change_o  (left_change_o),
    .right_change_o (right_change_o)
  );

endmodule

`default_nettype wire
